// ===== sv/rsa_modular_exponentiation_top_macros.svh =====
// Assertion macros shared by the RSA modular exponentiation RTL.
`ifndef RSA_MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define RSA_MODULAR_EXPONENTIATION_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RSA_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RSA_ASSERT_IMPLIES(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define RSA_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg)
`define RSA_ASSERT_IMPLIES(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ===== sv/rsa_mexp_pkg.sv =====
// Package with widths and register indexes of the RSA modular exponentiation block.
`default_nettype none

package rsa_mexp_pkg;

    localparam int MOD_BITS  = 31;
    localparam int EXP_BITS  = 31;
    localparam int MSG_W     = 32;
    localparam int RES_W     = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = $clog2(MSG_W);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_W-1:0]     t_cfg_data;
    typedef logic [MSG_W-1:0]     t_message;
    typedef logic [RES_W-1:0]     t_result;
    typedef logic [MOD_BITS-1:0]  t_mod;
    typedef logic [EXP_BITS-1:0]  t_exp;

    localparam t_cfg_idx REG_MODULUS          = 2'd0;
    localparam t_cfg_idx REG_PUBLIC_EXPONENT  = 2'd1;
    localparam t_cfg_idx REG_PRIVATE_EXPONENT = 2'd2;

endpackage

`default_nettype wire

// ===== sv/rsa_mexp_if.sv =====
// Request, result and configuration channel interfaces of the RSA block.
`default_nettype none

interface rsa_mexp_in_if import rsa_mexp_pkg::*; ();
    logic     valid;
    logic     ready;
    logic     mode;
    t_message message;

    modport source (output valid, output mode, output message, input ready);
    modport sink (input valid, input mode, input message, output ready);
endinterface

interface rsa_mexp_out_if import rsa_mexp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result result_value;

    modport source (output valid, output result_value, input ready);
    modport sink (input valid, input result_value, output ready);
endinterface

interface rsa_mexp_cfg_if import rsa_mexp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rsa_modular_exponentiation_top.sv =====
// Top level of the RSA modular exponentiation block with its bit-serial multiplier.
//
// The block computes message^exponent mod modulus for one request at a time.
// The configuration channel writes the modulus (index 0), the public exponent
// (index 1) and the private exponent (index 2); it is always ready.
// A request carries the mode bit, which selects the private exponent when set,
// and the message. One result follows every request on the output channel.
// All arithmetic runs through one shift-and-add modular multiplier that takes
// one multiplier bit per cycle.
// The message is first reduced by one pass through that multiplier. Each set
// exponent bit costs one more product, and each exponent bit below the highest
// set one costs a squaring. A new request is taken once the previous result
// has been loaded into the output register.
// A finished result waits in an output register, so the next request can
// start while the receiver stalls; a result that completes while that
// register is still full waits until it drains.
// Reset loads the modulus with 2 and both exponents with 0 and empties the
// output register.
`default_nettype none
`include "rsa_modular_exponentiation_top_macros.svh"

module rsa_modular_exponentiation_top import rsa_mexp_pkg::*; (
    input  wire             i_clk,
    input  wire             i_rst_n,
    rsa_mexp_cfg_if.sink    i_cfg,
    rsa_mexp_in_if.sink     i_in,
    rsa_mexp_out_if.source  o_out
);

    localparam int SUM_W = MOD_BITS + 2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_NEXT   = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;

    localparam logic [1:0] OP_REDUCE = 2'd0;
    localparam logic [1:0] OP_ACC    = 2'd1;
    localparam logic [1:0] OP_SQUARE = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MSG_W - 1);

    t_mod             r_modulus;
    t_exp             r_pub_exp;
    t_exp             r_priv_exp;
    logic [2:0]       r_state;
    logic [1:0]       r_op;
    t_exp             r_exp;
    t_mod             r_base;
    t_mod             r_acc;
    t_mod             r_mul_a;
    t_message         r_mul_b;
    t_mod             r_mul_p;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    t_result          r_out_data;

    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_mod_x1;
    logic [SUM_W-1:0] w_mod_x2;
    t_mod             n_mul_p;
    logic             w_out_free;
    logic             w_in_take;

    assign i_cfg.ready        = 1'b1;
    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_data;

    assign w_in_take  = i_in.valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;

    // One multiplier bit per cycle: p = (2p + bit * a) mod m, with 2p + a below 3m.
    assign w_mod_x1 = SUM_W'(r_modulus);
    assign w_mod_x2 = {1'b0, r_modulus, 1'b0};
    assign w_sum    = {1'b0, r_mul_p, 1'b0} + (r_mul_b[MSG_W-1] ? SUM_W'(r_mul_a) : '0);

    always_comb begin
        if (w_sum >= w_mod_x2) begin
            n_mul_p = MOD_BITS'(w_sum - w_mod_x2);
        end else if (w_sum >= w_mod_x1) begin
            n_mul_p = MOD_BITS'(w_sum - w_mod_x1);
        end else begin
            n_mul_p = MOD_BITS'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MOD_BITS'(2);
            r_pub_exp   <= '0;
            r_priv_exp  <= '0;
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_MODULUS:          r_modulus  <= MOD_BITS'(i_cfg.data);
                    REG_PUBLIC_EXPONENT:  r_pub_exp  <= EXP_BITS'(i_cfg.data);
                    REG_PRIVATE_EXPONENT: r_priv_exp <= EXP_BITS'(i_cfg.data);
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_take) begin
                        r_exp   <= i_in.mode ? r_priv_exp : r_pub_exp;
                        r_acc   <= (r_modulus < MOD_BITS'(2)) ? '0 : MOD_BITS'(1);
                        r_mul_a <= MOD_BITS'(1);
                        r_mul_b <= i_in.message;
                        r_mul_p <= '0;
                        r_cnt   <= CNT_LAST;
                        r_op    <= OP_REDUCE;
                        if (r_modulus < MOD_BITS'(2)) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_mul_p <= n_mul_p;
                    r_mul_b <= {r_mul_b[MSG_W-2:0], 1'b0};
                    r_cnt   <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        unique case (r_op)
                            OP_ACC: r_acc <= n_mul_p;
                            OP_SQUARE: begin
                                r_base <= n_mul_p;
                                r_exp  <= r_exp >> 1;
                            end
                            default: r_base <= n_mul_p;
                        endcase
                        r_state <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    r_mul_p <= '0;
                    r_cnt   <= CNT_LAST;
                    r_mul_b <= MSG_W'(r_base);
                    if ((r_op == OP_ACC) ? (r_exp[EXP_BITS-1:1] == '0) : (r_exp == '0)) begin
                        r_state <= ST_FINISH;
                    end else if ((r_op != OP_ACC) && r_exp[0]) begin
                        r_mul_a <= r_acc;
                        r_op    <= OP_ACC;
                        r_state <= ST_MUL;
                    end else begin
                        r_mul_a <= r_base;
                        r_op    <= OP_SQUARE;
                        r_state <= ST_MUL;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= RES_W'(r_acc);
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `RSA_ASSERT_HOLDS(a_partial_reduced, i_clk, i_rst_n, (r_state != ST_MUL) || (r_mul_p < r_modulus), "Partial product left the residue range.")
    `RSA_ASSERT_HOLDS(a_operands_reduced, i_clk, i_rst_n, (r_state != ST_NEXT) || ((r_base < r_modulus) && (r_acc < r_modulus)), "Base or accumulator not reduced.")
    `RSA_ASSERT_IMPLIES(a_request_starts, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> (r_state != ST_IDLE), "Accepted request did not start.")
    `RSA_ASSERT_IMPLIES(a_count_down, i_clk, i_rst_n, ((r_state == ST_MUL) && (r_cnt != '0)) |=> ((r_state == ST_MUL) && (r_cnt == $past(r_cnt) - CNT_W'(1))), "Multiplier left early or skipped a bit.")
    `RSA_ASSERT_IMPLIES(a_finish_loads, i_clk, i_rst_n, ((r_state == ST_FINISH) && w_out_free) |=> (r_out_valid && (r_state == ST_IDLE)), "Finished result not loaded into the output register.")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the RSA modular exponentiation block.
`default_nettype none

module testbench import rsa_mexp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       CLK_PERIOD   = 8;
    localparam int       RANDOM_ITEMS = 290;
    localparam int       DRAIN_CYCLES = 2100;
    localparam longint   LIMIT_CYCLES = 3_000_000;
    localparam logic     MODE_ENCRYPT = 1'b0;
    localparam logic     MODE_DECRYPT = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rsa_mexp_cfg_if cfg_if ();
    rsa_mexp_in_if  req_if ();
    rsa_mexp_out_if res_if ();

    rsa_modular_exponentiation_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    t_mod        key_modulus;
    t_exp        key_public;
    t_exp        key_private;
    t_result     pending_powers[$];
    int unsigned source_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned error_count;
    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned keys_loaded;
    longint      cycle_count;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_result mod_power(input t_message msg, input t_exp power, input t_mod m);
        logic [63:0] acc;
        logic [63:0] base;
        logic [63:0] modv;
        if (m < 2) begin
            return '0;
        end
        modv = 64'(m);
        acc  = 64'd1;
        base = 64'(msg) % modv;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (power[i]) begin
                acc = (acc * base) % modv;
            end
            base = (base * base) % modv;
        end
        return t_result'(acc);
    endfunction

    function automatic t_exp random_exponent();
        int unsigned pick;
        t_exp        x;
        pick = $urandom_range(0, 9);
        x = t_exp'($urandom);
        if (pick == 0) begin
            return '0;
        end
        if (pick >= 3) begin
            x = x & ((t_exp'(1) << $urandom_range(1, 16)) - t_exp'(1));
        end
        return x;
    endfunction

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_powers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, res_if.result_value);
                error_count++;
            end else begin
                want = pending_powers.pop_front();
                if (res_if.result_value !== want) begin
                    $display("%0t: result_value mismatch, expected %0d, actual %0d",
                             $time, want, res_if.result_value);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_powers.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic mode, input t_message msg);
        while ($urandom_range(0, 99) < source_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.mode    <= mode;
        req_if.message <= msg;
        do @(posedge i_clk); while (!req_if.ready);
        pending_powers.push_back(mod_power(msg, (mode == MODE_DECRYPT) ? key_private : key_public,
                                           key_modulus));
        requests_sent++;
    endtask

    task automatic wait_idle(input int settle_cycles);
        req_if.valid <= 1'b0;
        while (pending_powers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle_cycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_MODULUS:          key_modulus = t_mod'(value);
            REG_PUBLIC_EXPONENT:  key_public  = t_exp'(value);
            REG_PRIVATE_EXPONENT: key_private = t_exp'(value);
            default: ;
        endcase
    endtask

    task automatic load_key(input t_mod m, input t_exp e, input t_exp d);
        wait_idle(4);
        write_reg(REG_MODULUS, t_cfg_data'(m));
        write_reg(REG_PUBLIC_EXPONENT, t_cfg_data'(e));
        write_reg(REG_PRIVATE_EXPONENT, t_cfg_data'(d));
        cfg_if.valid <= 1'b0;
        keys_loaded++;
    endtask

    task automatic test_reset_values();
        send_request(MODE_ENCRYPT, 32'd5);
        send_request(MODE_DECRYPT, 32'hFFFF_FFFF);
    endtask

    task automatic test_operand_extremes();
        load_key('1, '1, t_exp'(1));
        send_request(MODE_ENCRYPT, 32'd0);
        send_request(MODE_ENCRYPT, 32'hFFFF_FFFF);
        send_request(MODE_DECRYPT, 32'hFFFF_FFFF);
        send_request(MODE_ENCRYPT, 32'h7FFF_FFFE);
        send_request(MODE_DECRYPT, 32'h7FFF_FFFF);
        load_key(t_mod'(2), t_exp'(1) << (EXP_BITS - 1), t_exp'(3));
        send_request(MODE_ENCRYPT, 32'd1);
        send_request(MODE_DECRYPT, 32'hFFFF_FFFE);
        send_request(MODE_DECRYPT, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_exponent();
        load_key(t_mod'(3233), '0, '0);
        send_request(MODE_ENCRYPT, 32'd1234);
        send_request(MODE_DECRYPT, 32'd0);
    endtask

    task automatic test_degenerate_modulus();
        load_key(t_mod'(1), t_exp'(17), '0);
        send_request(MODE_ENCRYPT, $urandom);
        send_request(MODE_DECRYPT, 32'hFFFF_FFFF);
        load_key('0, t_exp'(65537), t_exp'(9));
        send_request(MODE_ENCRYPT, $urandom);
        send_request(MODE_DECRYPT, 32'd7);
    endtask

    task automatic test_rsa_round_trip();
        t_message plain;
        load_key(t_mod'(3233), t_exp'(17), t_exp'(2753));
        send_request(MODE_ENCRYPT, 32'd65);
        send_request(MODE_DECRYPT, 32'(mod_power(32'd65, t_exp'(17), t_mod'(3233))));
        send_request(MODE_ENCRYPT, 32'd3232);
        plain = $urandom_range(2, 3231);
        send_request(MODE_ENCRYPT, plain);
        send_request(MODE_DECRYPT, 32'(mod_power(plain, t_exp'(17), t_mod'(3233))));
    endtask

    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned dst_pct,
                                       input int unsigned count);
        int unsigned sent;
        int unsigned batch;
        int unsigned width;
        t_mod        m;
        t_message    msg;
        wait_idle(4);
        source_idle_pct = src_pct;
        sink_idle_pct   = dst_pct;
        sent = 0;
        while (sent < count) begin
            width = $urandom_range(2, MOD_BITS);
            m = t_mod'($urandom) & ((t_mod'(1) << width) - t_mod'(1));
            m[width - 1] = 1'b1;
            load_key(m, random_exponent(), random_exponent());
            batch = $urandom_range(4, 14);
            for (int i = 0; i < batch && sent < count; i++) begin
                case ($urandom_range(0, 5))
                    0:       msg = '0;
                    1:       msg = '1;
                    2:       msg = 32'(m) - 32'd1;
                    3, 4:    msg = $urandom % 32'(m);
                    default: msg = $urandom;
                endcase
                send_request(logic'($urandom_range(0, 1)), msg);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= REG_MODULUS;
        cfg_if.data    <= '0;
        req_if.valid   <= 1'b0;
        req_if.mode    <= MODE_ENCRYPT;
        req_if.message <= '0;
        key_modulus     = t_mod'(2);
        key_public      = '0;
        key_private     = '0;
        source_idle_pct = 31;
        sink_idle_pct   = 82;
        error_count     = 0;
        requests_sent   = 0;
        results_seen    = 0;
        keys_loaded     = 0;
        cycle_count     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_operand_extremes();
        test_zero_exponent();
        test_degenerate_modulus();
        test_rsa_round_trip();
        test_random_traffic(31, 82, RANDOM_ITEMS / 3);
        test_random_traffic(82, 31, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        wait_idle(DRAIN_CYCLES);
        $display("Checked %0d of %0d requests across %0d key loads, in both modes.",
                 results_seen, requests_sent, keys_loaded);
        $display("Included zero exponents, moduli of zero, one and all ones, and full-width messages.");
        if (error_count == 0 && pending_powers.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/rsa_mexp_pkg.sv
sv/rsa_mexp_if.sv
sv/rsa_modular_exponentiation_top.sv
tb/sv/testbench.sv
